@@ rtl/trpa_pkg.sv @@
// Shared constants, command codes and control structs for the typed
// resource pool allocator. No dependencies.
`timescale 1ns / 1ps

package trpa_pkg;

  // Default pool depth and the group width of the typed search tree
  localparam int POOL_SIZE_DEF = 64;
  localparam int GROUP_SIZE    = 8;

  // Fixed field widths of the request and result ports
  localparam int CMD_W   = 2;
  localparam int TYPE_W  = 2;
  localparam int WANT_W  = 3;
  localparam int RID_W   = 7;
  localparam int CNT_W   = 7;
  localparam int TASK_W  = 32;

  localparam logic [RID_W-1:0] POOL_LIMIT_RST = 7'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  // Broadcast control for the per-id cells
  typedef struct packed {
    logic              clr;       // empty the whole pool
    logic              mk;        // create the selected id
    logic              take;      // acquire the selected id
    logic              give;      // release the selected id
    logic [TYPE_W-1:0] new_type;  // type of a created id
    logic [WANT_W-1:0] want;      // wanted type of an acquire, negative for any
  } id_ctrl_t;

  // Per-cell control of the free-id queue
  typedef struct packed {
    logic shift;  // take the neighbour's id
    logic load;   // take the pushed id
  } fifo_ctrl_t;

endpackage

@@ rtl/trpa_id_cell.sv @@
// One resource id of the pool: existence, free flag and type class.
// Depends on trpa_pkg for the control struct.
`timescale 1ns / 1ps

module trpa_id_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trpa_pkg::id_ctrl_t ctrl_i,
  input  logic               sel_i,
  output logic               exists_o,
  output logic               free_o,
  output logic               match_o
);
  import trpa_pkg::*;

  logic              exists_q;
  logic              free_q;
  logic [TYPE_W-1:0] type_q;

  // Update the flags when this id is selected, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q <= 1'b0;
      free_q   <= 1'b0;
    end else if (ctrl_i.clr) begin
      exists_q <= 1'b0;
      free_q   <= 1'b0;
    end else if (sel_i && ctrl_i.mk) begin
      exists_q <= 1'b1;
      free_q   <= 1'b1;
    end else if (sel_i && ctrl_i.take) begin
      free_q   <= 1'b0;
    end else if (sel_i && ctrl_i.give) begin
      free_q   <= 1'b1;
    end
  end

  // Hold the type class from the create request
  always_ff @(posedge clk_i) begin
    if (sel_i && ctrl_i.mk) begin
      type_q <= ctrl_i.new_type;
    end
  end

  assign exists_o = exists_q;
  assign free_o   = free_q;
  // Flag a free id of the wanted type; a negative wanted type matches nothing here
  assign match_o  = exists_q && free_q && !ctrl_i.want[WANT_W-1]
                    && (type_q == ctrl_i.want[TYPE_W-1:0]);

endmodule

@@ rtl/trpa_fifo_cell.sv @@
// One slot of the free-id queue; slots shift towards the head on removal.
// Depends on trpa_pkg for the control struct.
`timescale 1ns / 1ps

module trpa_fifo_cell #(
  parameter int ID_W = 7
) (
  input  logic                 clk_i,
  input  trpa_pkg::fifo_ctrl_t ctrl_i,
  input  logic [ID_W-1:0]      load_id_i,
  input  logic [ID_W-1:0]      nb_id_i,
  input  logic                 live_i,
  output logic [ID_W-1:0]      id_o,
  output logic                 match_o
);
  import trpa_pkg::*;

  logic [ID_W-1:0] id_q;

  // Load a pushed id, or advance the neighbour's id into this slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      id_q <= load_id_i;
    end else if (ctrl_i.shift) begin
      id_q <= nb_id_i;
    end
  end

  assign id_o    = id_q;
  assign match_o = live_i && (id_q == load_id_i);

endmodule

@@ rtl/typed_resource_pool_allocator.sv @@
// Typed resource pool allocator: id cells, free-id queue cells and the sequencer.
// Depends on trpa_pkg, trpa_id_cell and trpa_fifo_cell.
//
// Usage: a request (cmd_i, new_type_i, wanted_type_i, release_id_i, success_i) is
// taken at a rising edge with start high and busy low. Commands: create,
// acquire, release and clear pool. Each request gives exactly one result, shown
// for one cycle with done_o high: granted_id_o, ok_o and the pool totals after
// the command. The receiver cannot hold results off.
// Sequence: a request passes the three-step sequencer before done_o rises, and
// no new request is taken while one is in flight: the accepting edge registers
// the group level of the typed search tree, the pick cycle resolves the granted
// id, the apply cycle updates the id cells and shifts the free-id queue cells,
// and done_o is registered at the end of the apply cycle. A new request may be
// taken in the cycle in which done_o is high.
// The user writes pool_limit (pool_limit_we_i / pool_limit_wdata_i) only while
// idle; the block does not enforce it. Reset: empty pool, empty queue, next id 1,
// limit 64, counters zero; no clearing pass, requests are taken right after reset.
`timescale 1ns / 1ps

module typed_resource_pool_allocator #(
  parameter int POOL_SIZE = trpa_pkg::POOL_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [trpa_pkg::CMD_W-1:0]         cmd_i,
  input  logic [trpa_pkg::TYPE_W-1:0]        new_type_i,
  input  logic signed [trpa_pkg::WANT_W-1:0] wanted_type_i,
  input  logic [trpa_pkg::RID_W-1:0]         release_id_i,
  input  logic                               success_i,
  input  logic                               pool_limit_we_i,
  input  logic [trpa_pkg::RID_W-1:0]         pool_limit_wdata_i,
  output logic                               done_o,
  output logic [trpa_pkg::RID_W-1:0]         granted_id_o,
  output logic                               ok_o,
  output logic [trpa_pkg::CNT_W-1:0]         total_count_o,
  output logic [trpa_pkg::CNT_W-1:0]         free_count_o,
  output logic [trpa_pkg::CNT_W-1:0]         busy_count_o,
  output logic [trpa_pkg::TASK_W-1:0]        done_tasks_o,
  output logic [trpa_pkg::TASK_W-1:0]        reuse_total_o
);
  import trpa_pkg::*;

  localparam int IDW = $clog2(POOL_SIZE + 1);
  localparam int IXW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int NXW = $clog2(POOL_SIZE + 2);
  localparam int NG  = (POOL_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int HPW = NG * GROUP_SIZE;
  localparam int GXW = $clog2(GROUP_SIZE);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PICK  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       apply;

  // Request and configuration registers
  logic [RID_W-1:0]  pool_limit_q;
  logic [CMD_W-1:0]  cmd_q;
  logic [TYPE_W-1:0] new_type_q;
  logic [RID_W-1:0]  rel_q;

  // Pool state outside the cells
  logic [NXW-1:0]    next_id_q;
  logic [IDW-1:0]    fifo_count_q;
  logic [IDW-1:0]    total_q;
  logic [IDW-1:0]    free_q;
  logic [TASK_W-1:0] task_q;

  // Decisions taken in the pick cycle
  logic              create_ok_q;
  logic              acq_ok_q;
  logic              rel_ok_q;
  logic              rel_was_free_q;
  logic [IDW-1:0]    target_q;
  logic [RID_W-1:0]  res_id_q;
  logic              res_ok_q;
  logic              done_q;

  // Cell rows
  id_ctrl_t                 id_ctrl;
  logic [POOL_SIZE-1:0]     id_sel;
  logic [POOL_SIZE-1:0]     exists_vec;
  logic [POOL_SIZE-1:0]     free_vec;
  logic [POOL_SIZE-1:0]     type_hit;
  fifo_ctrl_t               fifo_ctrl [POOL_SIZE];
  logic [IDW-1:0]           fifo_id   [POOL_SIZE];
  logic [POOL_SIZE-1:0]     fifo_match;
  logic [POOL_SIZE-1:0]     fifo_live;

  // Typed search tree
  logic [HPW-1:0]  hit_pad;
  logic [NG-1:0]   grp_any_d, grp_any_q;
  logic [GXW-1:0]  grp_idx_d [NG];
  logic [GXW-1:0]  grp_idx_q [NG];
  logic            typed_found;
  logic [IDW-1:0]  typed_id;

  // Pick-cycle terms
  int              lim;
  logic            create_ok;
  logic            rel_in;
  logic [IXW-1:0]  rel_ix;
  logic [IDW-1:0]  acq_id;

  // Apply-cycle queue terms
  logic            q_remove;
  logic            q_push;
  logic            q_hit;
  logic            q_push_ok;
  logic [IXW-1:0]  q_pos;
  int              q_tail;

  assign accept = start && (state_q == S_IDLE);
  assign apply  = (state_q == S_APPLY);
  assign busy   = (state_q != S_IDLE);

  // Advance the sequencer
  always_comb begin
    case (state_q)
      S_IDLE:  state_d = accept ? S_PICK : S_IDLE;
      S_PICK:  state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Drive the id cells
  always_comb begin
    id_ctrl.clr      = apply && (cmd_q == CMD_CLEAR);
    id_ctrl.mk       = apply && create_ok_q;
    id_ctrl.take     = apply && acq_ok_q;
    id_ctrl.give     = apply && rel_ok_q;
    id_ctrl.new_type = new_type_q;
    id_ctrl.want     = wanted_type_i;
  end

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_id
    assign id_sel[i] = (target_q == IDW'(i + 1));
    trpa_id_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (id_ctrl),
      .sel_i    (id_sel[i]),
      .exists_o (exists_vec[i]),
      .free_o   (free_vec[i]),
      .match_o  (type_hit[i])
    );
  end

  // Group level of the typed search: lowest hit inside each group
  assign hit_pad = HPW'(type_hit);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
        if (hit_pad[g * GROUP_SIZE + k]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GXW'(k);
        end
      end
    end
  end

  // Top level of the typed search: lowest group with a hit
  always_comb begin
    typed_found = 1'b0;
    typed_id    = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        typed_found = 1'b1;
        typed_id    = IDW'(g * GROUP_SIZE + int'(grp_idx_q[g]) + 1);
      end
    end
  end

  // Resolve create, acquire and release outcomes
  always_comb begin
    lim       = (int'(pool_limit_q) > POOL_SIZE) ? POOL_SIZE : int'(pool_limit_q);
    create_ok = (next_id_q != '0) && (int'(next_id_q) <= lim);
    rel_in    = (rel_q != '0) && (int'(rel_q) <= POOL_SIZE);
    rel_ix    = IXW'(rel_q - 7'd1);
    if (typed_found) begin
      acq_id = typed_id;
    end else if (fifo_count_q != '0) begin
      acq_id = fifo_id[0];
    end else begin
      acq_id = '0;
    end
  end

  // Locate the id to remove in the queue and plan the push
  always_comb begin
    q_remove = apply && (acq_ok_q || rel_ok_q);
    q_push   = apply && (create_ok_q || rel_ok_q);
    q_hit    = q_remove && (|fifo_match);
    q_pos    = '0;
    for (int j = 0; j < POOL_SIZE; j++) begin
      if (fifo_match[j]) begin
        q_pos = q_pos | IXW'(j);
      end
    end
    q_tail    = int'(fifo_count_q) - (q_hit ? 1 : 0);
    q_push_ok = q_push && (q_hit || (int'(fifo_count_q) < POOL_SIZE));
  end

  for (genvar j = 0; j < POOL_SIZE; j++) begin : g_fifo
    logic [IDW-1:0] nb_id;
    if (j < POOL_SIZE - 1) begin : g_mid
      assign nb_id = fifo_id[j + 1];
    end else begin : g_end
      assign nb_id = fifo_id[j];
    end
    assign fifo_live[j]       = (int'(fifo_count_q) > j);
    assign fifo_ctrl[j].shift = q_hit && (j >= int'(q_pos));
    assign fifo_ctrl[j].load  = q_push_ok && (j == q_tail);
    trpa_fifo_cell #(
      .ID_W (IDW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (fifo_ctrl[j]),
      .load_id_i (target_q),
      .nb_id_i   (nb_id),
      .live_i    (fifo_live[j]),
      .id_o      (fifo_id[j]),
      .match_o   (fifo_match[j])
    );
  end

  // Capture the request and the group level of the search tree
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      new_type_q <= new_type_i;
      rel_q      <= release_id_i;
      grp_any_q  <= grp_any_d;
      grp_idx_q  <= grp_idx_d;
    end
  end

  // Sequencer, configuration, decisions and pool counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pool_limit_q   <= POOL_LIMIT_RST;
      next_id_q      <= NXW'(1);
      fifo_count_q   <= '0;
      total_q        <= '0;
      free_q         <= '0;
      task_q         <= '0;
      create_ok_q    <= 1'b0;
      acq_ok_q       <= 1'b0;
      rel_ok_q       <= 1'b0;
      rel_was_free_q <= 1'b0;
      target_q       <= '0;
      res_id_q       <= '0;
      res_ok_q       <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= apply;

      if (pool_limit_we_i) begin
        pool_limit_q <= pool_limit_wdata_i;
      end

      // Decide the outcome and the id the command works on
      if (state_q == S_PICK) begin
        create_ok_q    <= 1'b0;
        acq_ok_q       <= 1'b0;
        rel_ok_q       <= 1'b0;
        rel_was_free_q <= 1'b0;
        res_id_q       <= '0;
        res_ok_q       <= 1'b1;
        case (cmd_q)
          CMD_CREATE: begin
            create_ok_q <= create_ok;
            target_q    <= IDW'(next_id_q);
            res_id_q    <= create_ok ? RID_W'(next_id_q) : '0;
            res_ok_q    <= create_ok;
          end
          CMD_ACQUIRE: begin
            acq_ok_q <= (acq_id != '0);
            target_q <= acq_id;
            res_id_q <= RID_W'(acq_id);
            res_ok_q <= (acq_id != '0);
          end
          CMD_RELEASE: begin
            rel_ok_q       <= rel_in && exists_vec[rel_ix];
            rel_was_free_q <= free_vec[rel_ix];
            target_q       <= IDW'(rel_q);
            res_ok_q       <= rel_in && exists_vec[rel_ix];
          end
          default: begin
            target_q <= '0;
          end
        endcase
      end

      // Apply the command to the counters and the queue fill
      if (apply) begin
        if (cmd_q == CMD_CLEAR) begin
          fifo_count_q <= '0;
          total_q      <= '0;
          free_q       <= '0;
          task_q       <= '0;
        end else begin
          fifo_count_q <= fifo_count_q - IDW'(q_hit) + IDW'(q_push_ok);
          if (create_ok_q) begin
            next_id_q <= next_id_q + NXW'(1);
            total_q   <= total_q + IDW'(1);
            free_q    <= free_q + IDW'(1);
          end
          if (acq_ok_q) begin
            free_q <= free_q - IDW'(1);
          end
          if (rel_ok_q) begin
            if (!rel_was_free_q) begin
              free_q <= free_q + IDW'(1);
            end
            if (task_q != '1) begin
              task_q <= task_q + TASK_W'(1);
            end
          end
        end
      end
    end
  end

  assign done_o        = done_q;
  assign granted_id_o  = res_id_q;
  assign ok_o          = res_ok_q;
  assign total_count_o = CNT_W'(total_q);
  assign free_count_o  = CNT_W'(free_q);
  assign busy_count_o  = CNT_W'(total_q - free_q);
  assign done_tasks_o  = task_q;
  assign reuse_total_o = task_q;

`ifndef SYNTHESIS
  // The queue fill always equals the free count of the pool
  a_fifo_tracks_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count_q == free_q)
    else $error("free-id queue fill differs from free count");

  // Never more free ids than ids in the pool
  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= total_q)
    else $error("free count exceeds pool count");

  // A result only follows an apply cycle
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_APPLY))
    else $error("result strobe without an apply cycle");

  // The next id stays between 1 and POOL_SIZE + 1
  a_next_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != '0) && (int'(next_id_q) <= POOL_SIZE + 1))
    else $error("next id out of range");
`endif

endmodule
